// ===== hw/rtl/grpu_pkg.sv =====
// shared constants and types for the gamma rgb565 pixel upscaler
package grpu_pkg;

    // gamma table geometry
    localparam int GAMMA_ENTRIES = 256;
    localparam int GAMMA_AW      = $clog2(GAMMA_ENTRIES);

    // stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    // item kind carried in s_tuser
    localparam logic MODE_TABLE = 1'b0;
    localparam logic MODE_DRAW  = 1'b1;

    // canvas_mode register codes
    localparam logic [1:0] CANVAS_16 = 2'd0;
    localparam logic [1:0] CANVAS_32 = 2'd1;
    localparam logic [1:0] CANVAS_64 = 2'd2;

    // one decoded draw item handed from the front stage to the block emitter
    typedef struct packed {
        logic [5:0] base_x;
        logic [5:0] base_y;
        logic [1:0] scale_m1;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } grpu_pix_t;

endpackage

// ===== hw/rtl/gamma_rgb565_pixel_upscaler.sv =====
// top level of the gamma-corrected rgb565 nearest-neighbor pixel upscaler
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata (index, color, table addr/value), s_tuser kind
//  m_        out  m_tvalid/m_tready  m_tdata (panel x, panel y, rgb565), m_tlast
//  cfg_      in   cfg_we             cfg_wdata = canvas_mode
//
//  a draw item yields 16, 4 or 1 results for canvas side 16, 32 or 64, one per cycle
//  while m_tready is high, so it occupies the block emitter until its last result is taken
//  table writes, clipped indexes and canvas mode 3 give no result
//  an accepted item passes the table read register, then the emitter output register
//  the next item is taken while the current block is still being emitted
//  reset clears the valid flags and sets canvas_mode to 0; the gamma table is not cleared
module gamma_rgb565_pixel_upscaler import grpu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pixel_index[11:0], rgb_color[35:12],
                                            // table_addr[43:36], table_value[51:44], zero pad
    input  logic                 s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // panel_x[5:0], panel_y[11:6], rgb565[27:12],
                                            // zero pad
    output logic                 m_tlast    // last
);

    logic      pix_valid;
    logic      pix_ready;
    grpu_pix_t pix;

    // decode and gamma lookup
    grpu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    // block replication
    grpu_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // a stalled decoded item holds between the two stages
    assert property (@(posedge aclk) disable iff (!aresetn)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix))
        else $error("decoded item changed while stalled");

    // a block is never cut short
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("block ended without last");

    // color stays the same across one block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tdata[27:12] == $past(m_tdata[27:12]))
        else $error("color changed within a block");

    // a table write never reaches the emitter
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == MODE_TABLE) |=> !pix_valid)
        else $error("table write produced a draw");

endmodule

// ===== hw/rtl/grpu_front.sv =====
// front stage: canvas register, index decode and the three gamma table copies
module grpu_front import grpu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 pix_valid,
    input  logic                 pix_ready,
    output grpu_pix_t            pix
);

    logic [1:0]  canvas_mode_reg;
    logic        a_valid_reg;
    logic        a_valid_next;
    logic [5:0]  base_x_reg;
    logic [5:0]  base_y_reg;
    logic [1:0]  scale_m1_reg;
    logic [7:0]  rd_r_reg;
    logic [7:0]  rd_g_reg;
    logic [7:0]  rd_b_reg;

    logic [7:0]  gamma_r_mem [GAMMA_ENTRIES];
    logic [7:0]  gamma_g_mem [GAMMA_ENTRIES];
    logic [7:0]  gamma_b_mem [GAMMA_ENTRIES];

    logic [11:0] pixel_index;
    logic [23:0] rgb_color;
    logic [GAMMA_AW-1:0] table_addr;
    logic [7:0]  table_value;
    logic        s_accept;
    logic        in_range;
    logic [5:0]  dec_x;
    logic [5:0]  dec_y;
    logic [1:0]  dec_scale_m1;

    // unpack the input item
    assign pixel_index = s_tdata[11:0];
    assign rgb_color   = s_tdata[35:12];
    assign table_addr  = s_tdata[43:36];
    assign table_value = s_tdata[51:44];

    assign s_tready = !a_valid_reg || pix_ready;
    assign s_accept = s_tvalid && s_tready;

    // canvas size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            canvas_mode_reg <= CANVAS_16;
        end else if (cfg_we) begin
            canvas_mode_reg <= cfg_wdata;
        end
    end

    // split the linear index into block origin on the panel
    always_comb begin
        in_range     = 1'b0;
        dec_x        = '0;
        dec_y        = '0;
        dec_scale_m1 = 2'd0;
        case (canvas_mode_reg)
            CANVAS_16: begin
                in_range     = (pixel_index[11:8] == 4'd0);
                dec_x        = {pixel_index[3:0], 2'b00};
                dec_y        = {pixel_index[7:4], 2'b00};
                dec_scale_m1 = 2'd3;
            end
            CANVAS_32: begin
                in_range     = (pixel_index[11:10] == 2'd0);
                dec_x        = {pixel_index[4:0], 1'b0};
                dec_y        = {pixel_index[9:5], 1'b0};
                dec_scale_m1 = 2'd1;
            end
            CANVAS_64: begin
                in_range     = 1'b1;
                dec_x        = pixel_index[5:0];
                dec_y        = pixel_index[11:6];
                dec_scale_m1 = 2'd0;
            end
            default: begin
                in_range = 1'b0;
            end
        endcase
    end

    // stage valid: only in-range draw items go on
    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_tready) begin
            a_valid_next = s_accept && (s_tuser == MODE_DRAW) && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    // block origin held with the table read
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            base_x_reg   <= dec_x;
            base_y_reg   <= dec_y;
            scale_m1_reg <= dec_scale_m1;
        end
    end

    // gamma table copies, one per channel, all written together
    always_ff @(posedge aclk) begin
        if (s_accept && (s_tuser == MODE_TABLE)) begin
            gamma_r_mem[table_addr] <= table_value;
            gamma_g_mem[table_addr] <= table_value;
            gamma_b_mem[table_addr] <= table_value;
        end
    end

    // registered channel lookups
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_r_reg <= gamma_r_mem[rgb_color[23:16]];
            rd_g_reg <= gamma_g_mem[rgb_color[15:8]];
            rd_b_reg <= gamma_b_mem[rgb_color[7:0]];
        end
    end

    assign pix_valid    = a_valid_reg;
    assign pix.base_x   = base_x_reg;
    assign pix.base_y   = base_y_reg;
    assign pix.scale_m1 = scale_m1_reg;
    assign pix.red      = rd_r_reg;
    assign pix.green    = rd_g_reg;
    assign pix.blue     = rd_b_reg;

endmodule

// ===== hw/rtl/grpu_emit.sv =====
// block emitter: packs rgb565 and walks the replicated block one panel pixel per cycle while m_tready is high
module grpu_emit import grpu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pix_valid,
    output logic                 pix_ready,
    input  grpu_pix_t            pix,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic        out_valid_reg, out_valid_next;
    logic [5:0]  x_reg, x_next;
    logic [5:0]  y_reg, y_next;
    logic [15:0] color_reg, color_next;
    logic        last_reg, last_next;
    logic [1:0]  dx_reg, dx_next;
    logic [1:0]  dy_reg, dy_next;
    logic [5:0]  base_y_reg, base_y_next;
    logic [1:0]  scale_m1_reg, scale_m1_next;
    logic        m_accept;
    logic        load;

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    assign m_accept  = m_tvalid && m_tready;
    assign pix_ready = !out_valid_reg || (m_tready && last_reg);
    assign load      = pix_valid && pix_ready;

    // next block position: down the column, then on to the next column
    always_comb begin
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        color_next     = color_reg;
        last_next      = last_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        base_y_next    = base_y_reg;
        scale_m1_next  = scale_m1_reg;
        if (load) begin
            out_valid_next = 1'b1;
            x_next         = pix.base_x;
            y_next         = pix.base_y;
            color_next     = pack565(pix.red, pix.green, pix.blue);
            last_next      = (pix.scale_m1 == 2'd0);
            dx_next        = 2'd0;
            dy_next        = 2'd0;
            base_y_next    = pix.base_y;
            scale_m1_next  = pix.scale_m1;
        end else if (m_accept) begin
            if (last_reg) begin
                out_valid_next = 1'b0;
            end else if (dy_reg == scale_m1_reg) begin
                dy_next = 2'd0;
                dx_next = dx_reg + 2'd1;
                x_next  = x_reg + 6'd1;
                y_next  = base_y_reg;
            end else begin
                dy_next = dy_reg + 2'd1;
                y_next  = y_reg + 6'd1;
            end
            last_next = (dx_next == scale_m1_reg) && (dy_next == scale_m1_reg);
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload and walk counters
    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        color_reg    <= color_next;
        last_reg     <= last_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        base_y_reg   <= base_y_next;
        scale_m1_reg <= scale_m1_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, color_reg, y_reg, x_reg};
    assign m_tlast  = last_reg;

endmodule
